// ----- rtl/shell_word_lexer_defines.svh -----
// assertion macros for the shell word lexer
// used by the rtl modules that check their own logic; no dependencies
`ifndef SHELL_WORD_LEXER_DEFINES_SVH
`define SHELL_WORD_LEXER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising clk_i edge outside reset
`define SWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition that must never be true outside reset
`define SWL_ASSERT_NEVER(lbl, cond, msg) \
  `SWL_ASSERT(lbl, !(cond), msg)
`else
`define SWL_ASSERT(lbl, prop, msg)
`define SWL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/swl_pkg.sv -----
// shared types, codes and constants of the shell word lexer
// no dependencies; used by every rtl module of the block
package swl_pkg;

  // characters with a meaning of their own
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // open quote codes reported at line end
  localparam logic [1:0] OQ_NONE   = 2'd0;
  localparam logic [1:0] OQ_SINGLE = 2'd1;
  localparam logic [1:0] OQ_DOUBLE = 2'd2;

  // configuration register indexes
  localparam logic CFG_COMPLETION_MODE   = 1'b0;
  localparam logic CFG_ACCEPT_OPEN_QUOTE = 1'b1;

  // default depth of the run queue between front and back
  localparam int unsigned RUN_FIFO_DEPTH = 4;

  // most results one input item can cause
  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_WORD_END  = 2'd1,
    KIND_LINE_DONE = 2'd2,
    KIND_REJECTED  = 2'd3
  } kind_e;

  // lexer mode, one-hot
  typedef enum logic [3:0] {
    LEX_BETWEEN     = 4'b0001,
    LEX_BARE        = 4'b0010,
    LEX_QUOTED      = 4'b0100,
    LEX_AFTER_QUOTE = 4'b1000
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] word_char;
    logic [1:0] open_quote;
    logic       last_of_run;
  } out_item_t;

  // one result without its position in the run
  typedef struct packed {
    kind_e      kind;
    logic [7:0] word_char;
    logic [1:0] open_quote;
  } res_t;

  // all results of one input item
  typedef struct packed {
    logic [1:0]                 count;
    res_t [MAX_RESULTS-1:0]     res;
  } run_t;

  // front to queue
  typedef struct packed {
    logic valid;
    run_t run;
  } run_push_t;

  // queue to back
  typedef struct packed {
    logic empty;
    run_t head;
  } run_head_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] ch, logic [1:0] oq);
    res_t r;
    r.kind       = kind;
    r.word_char  = ch;
    r.open_quote = oq;
    return r;
  endfunction

endpackage

// ----- rtl/swl_front.sv -----
// front part: takes characters, tracks the lexer state, builds result runs
// depends on swl_pkg and shell_word_lexer_defines.svh
`include "shell_word_lexer_defines.svh"

module swl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  swl_pkg::in_item_t   item_i,
  input  logic                q_full_i,
  output swl_pkg::run_push_t  run_o
);

  logic                completion_q;
  logic                accept_open_q;
  swl_pkg::lex_mode_e  lex_mode_q, lex_mode_d;
  logic                dquote_q, dquote_d;
  logic                esc_q, esc_d;
  logic                word_open_q, word_open_d;
  logic                ended_blank_q, ended_blank_d;
  logic                fire;
  swl_pkg::run_t       run_d;

  assign full = q_full_i;
  assign fire = push && !q_full_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      completion_q  <= 1'b0;
      accept_open_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swl_pkg::CFG_COMPLETION_MODE:   completion_q  <= cfg_wdata_i;
        swl_pkg::CFG_ACCEPT_OPEN_QUOTE: accept_open_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // lexer step and result run for one item
  always_comb begin
    logic [1:0] n;
    logic [7:0] c;
    logic [7:0] q;
    logic [1:0] oq;
    n             = 2'd0;
    c             = item_i.char_in;
    q             = dquote_q ? swl_pkg::CH_DQUOTE : swl_pkg::CH_SQUOTE;
    oq            = dquote_q ? swl_pkg::OQ_DOUBLE : swl_pkg::OQ_SINGLE;
    run_d         = '0;
    lex_mode_d    = lex_mode_q;
    dquote_d      = dquote_q;
    esc_d         = esc_q;
    word_open_d   = word_open_q;
    ended_blank_d = ended_blank_q;
    if (item_i.line_end) begin
      if (lex_mode_q == swl_pkg::LEX_QUOTED) begin
        if (!accept_open_q) begin
          run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_REJECTED, 8'h00, oq);
          n = n + 2'd1;
        end else begin
          if (esc_q) begin
            run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_CHAR, swl_pkg::CH_BSLASH,
                                           swl_pkg::OQ_NONE);
            n = n + 2'd1;
          end
          run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
          n = n + 2'd1;
          run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_LINE_DONE, 8'h00, oq);
          n = n + 2'd1;
        end
      end else begin
        if (word_open_q || (completion_q && ended_blank_q)) begin
          run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
          n = n + 2'd1;
        end
        run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_LINE_DONE, 8'h00, swl_pkg::OQ_NONE);
        n = n + 2'd1;
      end
      lex_mode_d    = swl_pkg::LEX_BETWEEN;
      dquote_d      = 1'b0;
      esc_d         = 1'b0;
      word_open_d   = 1'b0;
      ended_blank_d = 1'b1;
    end else if (lex_mode_q == swl_pkg::LEX_QUOTED) begin
      if (esc_q) begin
        esc_d = 1'b0;
        if (c != q && c != swl_pkg::CH_BSLASH) begin
          run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_CHAR, swl_pkg::CH_BSLASH,
                                         swl_pkg::OQ_NONE);
          n = n + 2'd1;
        end
        run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
        n = n + 2'd1;
      end else if (c == swl_pkg::CH_BSLASH) begin
        esc_d = 1'b1;
      end else if (c == q) begin
        lex_mode_d = swl_pkg::LEX_AFTER_QUOTE;
      end else begin
        run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
        n = n + 2'd1;
      end
    end else if (c inside {swl_pkg::CH_SPACE, swl_pkg::CH_TAB}) begin
      if (word_open_q) begin
        run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
        n = n + 2'd1;
      end
      word_open_d   = 1'b0;
      lex_mode_d    = swl_pkg::LEX_BETWEEN;
      ended_blank_d = 1'b1;
    end else begin
      word_open_d   = 1'b1;
      ended_blank_d = 1'b0;
      if (lex_mode_q != swl_pkg::LEX_BARE &&
          (c == swl_pkg::CH_SQUOTE || c == swl_pkg::CH_DQUOTE)) begin
        lex_mode_d = swl_pkg::LEX_QUOTED;
        dquote_d   = (c == swl_pkg::CH_DQUOTE);
        esc_d      = 1'b0;
      end else begin
        lex_mode_d = swl_pkg::LEX_BARE;
        run_d.res[n] = swl_pkg::mk_res(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
        n = n + 2'd1;
      end
    end
    run_d.count = n;
  end

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_mode_q    <= swl_pkg::LEX_BETWEEN;
      dquote_q      <= 1'b0;
      esc_q         <= 1'b0;
      word_open_q   <= 1'b0;
      ended_blank_q <= 1'b1;
    end else if (fire) begin
      lex_mode_q    <= lex_mode_d;
      dquote_q      <= dquote_d;
      esc_q         <= esc_d;
      word_open_q   <= word_open_d;
      ended_blank_q <= ended_blank_d;
    end
  end

  // only runs with results go to the queue
  assign run_o.valid = fire && (run_d.count != 2'd0);
  assign run_o.run   = run_d;

  `SWL_ASSERT(a_esc_only_quoted, esc_q |-> (lex_mode_q == swl_pkg::LEX_QUOTED), "escape outside quotes")
  `SWL_ASSERT(a_word_open_in_word, (lex_mode_q != swl_pkg::LEX_BETWEEN) |-> word_open_q, "segment without open word")

endmodule

// ----- rtl/swl_run_fifo.sv -----
// short queue of result runs between the front and the back part
// depends on swl_pkg and shell_word_lexer_defines.svh
`include "shell_word_lexer_defines.svh"

module swl_run_fifo #(
  parameter int unsigned Depth = swl_pkg::RUN_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swl_pkg::run_push_t  push_i,
  input  logic                pop_i,
  output logic                full_o,
  output swl_pkg::run_head_t  head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  swl_pkg::run_t  mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_pop;

  assign full_o       = (cnt_q == CW'(Depth));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.head  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && !head_o.empty;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.run;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      case ({push_i.valid, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

  `SWL_ASSERT_NEVER(a_no_overflow, push_i.valid && full_o, "run pushed into full queue")

endmodule

// ----- rtl/swl_back.sv -----
// back part: hands out the results of the head run one transfer at a time
// depends on swl_pkg and shell_word_lexer_defines.svh
`include "shell_word_lexer_defines.svh"

module swl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swl_pkg::run_head_t  head_i,
  output logic                run_pop_o,
  input  logic                pop,
  output logic                empty,
  output swl_pkg::out_item_t  result_o
);

  logic [1:0]     idx_q;
  logic           last;
  logic           fire;
  swl_pkg::res_t  cur;

  assign empty = head_i.empty;
  assign cur   = head_i.head.res[idx_q];
  assign last  = (idx_q == head_i.head.count - 2'd1);
  assign fire  = pop && !head_i.empty;

  // result fields of the current position
  assign result_o.kind        = cur.kind;
  assign result_o.word_char   = cur.word_char;
  assign result_o.open_quote  = cur.open_quote;
  assign result_o.last_of_run = last;

  assign run_pop_o = fire && last;

  // position within the head run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  `SWL_ASSERT(a_run_nonempty, !head_i.empty |-> (head_i.head.count != 2'd0), "empty run queued")
  `SWL_ASSERT(a_idx_in_run, !head_i.empty |-> (idx_q < head_i.head.count), "position beyond run")

endmodule

// ----- rtl/shell_word_lexer.sv -----
// top level of the shell word lexer: front, run queue and back part
// depends on swl_pkg, swl_front, swl_run_fifo and swl_back
//
//   channel   ports                          moves
//   input     push, full, item_i             one character or a line end
//   result    empty, pop, result_o           one result per transfer
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i  one register write
//
// an item is taken every cycle while the run queue has room; its results
// leave one per cycle while pop is held, so the sustained rate is set by
// the result side (items without results are not queued).
// an item's results are written into the run queue as it is taken and
// leave from its head; reset clears lexer state, queue and registers;
// stalls on pop back up the queue of FifoDepth runs, then full rises.
module shell_word_lexer #(
  parameter int unsigned FifoDepth = swl_pkg::RUN_FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  swl_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output swl_pkg::out_item_t  result_o
);

  swl_pkg::run_push_t  run_push;
  swl_pkg::run_head_t  run_head;
  logic                q_full;
  logic                run_pop;

  // character classification and lexer state
  swl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .q_full_i    (q_full),
    .run_o       (run_push)
  );

  // decoupling queue of result runs
  swl_run_fifo #(
    .Depth (FifoDepth)
  ) u_run_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (run_push),
    .pop_i  (run_pop),
    .full_o (q_full),
    .head_o (run_head)
  );

  // result serializer
  swl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (run_head),
    .run_pop_o (run_pop),
    .pop       (pop),
    .empty     (empty),
    .result_o  (result_o)
  );

endmodule

// ----- verif/tb_shell_word_lexer.sv -----
// self-checking testbench of shell_word_lexer: random and directed lines, tokens checked
// against a built-in lexer of its own; depends on swl_pkg and the shell_word_lexer rtl
`timescale 1ns / 1ps

module tb_shell_word_lexer;

  // clock, reset and block ports
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                push = 1'b0;
  logic                full;
  swl_pkg::in_item_t   item_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  swl_pkg::out_item_t  result_o;

  // shadow registers and lexer state of the predictor
  logic                cfg_completion;
  logic                cfg_accept_open;
  swl_pkg::lex_mode_e  lx_mode;
  logic                lx_dq;
  logic                lx_esc;
  logic                lx_word_open;
  logic                lx_blank_end;

  // characters waiting to be sent and tokens waiting to come back
  swl_pkg::in_item_t   pending_chars[$];
  swl_pkg::out_item_t  step_tokens[$];
  swl_pkg::out_item_t  expected_tokens[$];
  swl_pkg::out_item_t  want;
  int                  chars_queued;
  int                  mismatch_count;
  int                  send_gap;
  int                  send_burst;
  int                  pop_stall;
  int                  pop_burst;

  shell_word_lexer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // predictor: one token of the current step
  task automatic put_token(input swl_pkg::kind_e k, input logic [7:0] ch,
                           input logic [1:0] oq);
    swl_pkg::out_item_t t;
    t.kind        = k;
    t.word_char   = ch;
    t.open_quote  = oq;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endtask

  // predictor: tokens caused by one accepted character or line end
  task automatic lex_step(input swl_pkg::in_item_t it);
    logic [7:0]         c;
    logic [7:0]         q;
    logic [1:0]         oq;
    swl_pkg::out_item_t t;
    c = it.char_in;
    step_tokens.delete();
    if (it.line_end) begin
      if (lx_mode == swl_pkg::LEX_QUOTED) begin
        oq = lx_dq ? swl_pkg::OQ_DOUBLE : swl_pkg::OQ_SINGLE;
        if (!cfg_accept_open) begin
          put_token(swl_pkg::KIND_REJECTED, 8'h00, oq);
        end else begin
          if (lx_esc) put_token(swl_pkg::KIND_CHAR, swl_pkg::CH_BSLASH, swl_pkg::OQ_NONE);
          put_token(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
          put_token(swl_pkg::KIND_LINE_DONE, 8'h00, oq);
        end
      end else begin
        if (lx_word_open || (cfg_completion && lx_blank_end)) begin
          put_token(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
        end
        put_token(swl_pkg::KIND_LINE_DONE, 8'h00, swl_pkg::OQ_NONE);
      end
      lx_mode      = swl_pkg::LEX_BETWEEN;
      lx_dq        = 1'b0;
      lx_esc       = 1'b0;
      lx_word_open = 1'b0;
      lx_blank_end = 1'b1;
    end else if (lx_mode == swl_pkg::LEX_QUOTED) begin
      q = lx_dq ? swl_pkg::CH_DQUOTE : swl_pkg::CH_SQUOTE;
      if (lx_esc) begin
        lx_esc = 1'b0;
        if (c != q && c != swl_pkg::CH_BSLASH) begin
          put_token(swl_pkg::KIND_CHAR, swl_pkg::CH_BSLASH, swl_pkg::OQ_NONE);
        end
        put_token(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
      end else if (c == swl_pkg::CH_BSLASH) begin
        lx_esc = 1'b1;
      end else if (c == q) begin
        lx_mode = swl_pkg::LEX_AFTER_QUOTE;
      end else begin
        put_token(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
      end
    end else if (c == swl_pkg::CH_SPACE || c == swl_pkg::CH_TAB) begin
      if (lx_word_open) put_token(swl_pkg::KIND_WORD_END, 8'h00, swl_pkg::OQ_NONE);
      lx_word_open = 1'b0;
      lx_mode      = swl_pkg::LEX_BETWEEN;
      lx_blank_end = 1'b1;
    end else begin
      lx_word_open = 1'b1;
      lx_blank_end = 1'b0;
      if (lx_mode != swl_pkg::LEX_BARE &&
          (c == swl_pkg::CH_SQUOTE || c == swl_pkg::CH_DQUOTE)) begin
        lx_mode = swl_pkg::LEX_QUOTED;
        lx_dq   = (c == swl_pkg::CH_DQUOTE);
        lx_esc  = 1'b0;
      end else begin
        lx_mode = swl_pkg::LEX_BARE;
        put_token(swl_pkg::KIND_CHAR, c, swl_pkg::OQ_NONE);
      end
    end
    // mark the last token of the step and queue them all
    if (step_tokens.size() != 0) begin
      t = step_tokens.pop_back();
      t.last_of_run = 1'b1;
      step_tokens.push_back(t);
    end
    while (step_tokens.size() != 0) expected_tokens.push_back(step_tokens.pop_front());
  endtask

  // input driver: one transfer per free cycle unless a gap is running
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) lex_step(item_i);
      if (push && full) begin
        // hold the item until it is taken
      end else if (send_gap != 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (pending_chars.size() != 0) begin
        item_i <= pending_chars.pop_front();
        push   <= 1'b1;
        if (send_burst != 0) begin
          send_burst--;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 29) == 0) send_burst = $urandom_range(16, 48);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor: random pop stalls, field by field compare
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected token kind %0d char %02h oq %0d",
                                    result_o.kind, result_o.word_char, result_o.open_quote));
        end else begin
          want = expected_tokens.pop_front();
          if (result_o.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", result_o.kind, want.kind));
          if (result_o.word_char !== want.word_char)
            report_mismatch($sformatf("word_char %02h, want %02h",
                                      result_o.word_char, want.word_char));
          if (result_o.open_quote !== want.open_quote)
            report_mismatch($sformatf("open_quote %0d, want %0d",
                                      result_o.open_quote, want.open_quote));
          if (result_o.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b",
                                      result_o.last_of_run, want.last_of_run));
        end
      end
      if (pop_stall != 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        pop <= 1'b1;
        if (pop_burst != 0) begin
          pop_burst--;
        end else begin
          pop_stall = idle_len();
          if ($urandom_range(0, 29) == 0) pop_burst = $urandom_range(16, 48);
        end
      end
    end
  end

  // stimulus helpers
  task automatic add_item(input logic [7:0] c, input logic le);
    swl_pkg::in_item_t it;
    it.char_in  = c;
    it.line_end = le;
    pending_chars.push_back(it);
    chars_queued++;
  endtask

  task automatic add_char(input logic [7:0] c);
    add_item(c, 1'b0);
  endtask

  // the character field is don't-care on a line end, so it is random
  task automatic add_end();
    add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic add_blank();
    add_char($urandom_range(0, 1) ? swl_pkg::CH_SPACE : swl_pkg::CH_TAB);
  endtask

  function automatic logic [7:0] special_char();
    case ($urandom_range(0, 4))
      0: return swl_pkg::CH_SPACE;
      1: return swl_pkg::CH_TAB;
      2: return swl_pkg::CH_DQUOTE;
      3: return swl_pkg::CH_SQUOTE;
      default: return swl_pkg::CH_BSLASH;
    endcase
  endfunction

  // any character but a blank; quotes and backslashes included
  function automatic logic [7:0] bare_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == swl_pkg::CH_SPACE || c == swl_pkg::CH_TAB);
    return c;
  endfunction

  // quoted segment with escapes of all sorts, left open if asked
  task automatic add_quoted(input logic leave_open);
    logic [7:0] q;
    logic [7:0] c;
    int         n;
    q = $urandom_range(0, 1) ? swl_pkg::CH_DQUOTE : swl_pkg::CH_SQUOTE;
    n = $urandom_range(0, 6);
    add_char(q);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin add_char(swl_pkg::CH_BSLASH); add_char(q); end
        1: begin add_char(swl_pkg::CH_BSLASH); add_char(swl_pkg::CH_BSLASH); end
        2: begin add_char(swl_pkg::CH_BSLASH); add_char(special_char()); end
        3: begin add_char(swl_pkg::CH_BSLASH); add_char(bare_char()); end
        4: add_blank();
        default: begin
          do c = 8'($urandom_range(0, 255));
          while (c == q || c == swl_pkg::CH_BSLASH);
          add_char(c);
        end
      endcase
    end
    if (leave_open) begin
      if ($urandom_range(0, 2) == 0) add_char(swl_pkg::CH_BSLASH);
    end else begin
      add_char(q);
    end
  endtask

  // line of words made of joined bare and quoted segments, last quote at times left open
  task automatic add_line();
    int  words;
    int  segs;
    logic open_end;
    words    = $urandom_range(0, 4);
    open_end = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 3) == 0) add_blank();
    for (int w = 0; w < words; w++) begin
      if (w != 0) begin
        add_blank();
        if ($urandom_range(0, 2) == 0) add_blank();
      end
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 4)) add_char(bare_char());
        end else begin
          add_quoted(open_end && w == words - 1 && s == segs - 1);
        end
      end
    end
    if ($urandom_range(0, 3) == 0) add_blank();
    add_end();
  endtask

  // noise: random bytes heavy in blanks, quotes and backslashes
  task automatic add_noise_line();
    repeat ($urandom_range(0, 10)) begin
      add_char($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : special_char());
    end
    add_end();
  endtask

  task automatic random_lines(input int count);
    int stop_at;
    stop_at = chars_queued + count;
    while (chars_queued < stop_at) begin
      if ($urandom_range(0, 5) == 0) add_noise_line();
      else add_line();
    end
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == swl_pkg::CFG_COMPLETION_MODE) cfg_completion = val;
    else cfg_accept_open = val;
  endtask

  task automatic set_modes(input logic completion, input logic accept_open);
    write_reg(swl_pkg::CFG_COMPLETION_MODE, completion);
    write_reg(swl_pkg::CFG_ACCEPT_OPEN_QUOTE, accept_open);
  endtask

  // wait for every token, then let the pipeline settle
  task automatic drain();
    while (pending_chars.size() != 0 || push || expected_tokens.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (24) @(posedge clk_i);
  endtask

  // main sequence
  initial begin
    cfg_completion  = 1'b0;
    cfg_accept_open = 1'b0;
    lx_mode         = swl_pkg::LEX_BETWEEN;
    lx_dq           = 1'b0;
    lx_esc          = 1'b0;
    lx_word_open    = 1'b0;
    lx_blank_end    = 1'b1;
    chars_queued    = 0;
    mismatch_count  = 0;
    send_gap        = 0;
    send_burst      = 0;
    pop_stall       = 0;
    pop_burst       = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty line, blanks kept in quotes, escapes, joined segments,
    // quote inside a bare word, extreme codes, open quote with a pending backslash
    set_modes(1'b1, 1'b1);
    add_end();
    add_text("a\t'b c'\"\\\"\\\\\\q\"e'");
    add_end();
    add_char(8'h00);
    add_char(8'hFF);
    add_char(swl_pkg::CH_SPACE);
    add_end();
    add_text("\"x\\");
    add_end();
    drain();

    // random lines under every register setting
    set_modes(1'b0, 1'b0);
    random_lines(100);
    drain();
    set_modes(1'b1, 1'b0);
    random_lines(100);
    drain();
    set_modes(1'b0, 1'b1);
    random_lines(100);
    drain();
    set_modes(1'b1, 1'b1);
    random_lines(100);
    drain();

    if (expected_tokens.size() != 0) begin
      report_mismatch($sformatf("%0d tokens never came", expected_tokens.size()));
    end
    if (mismatch_count == 0) begin
      $display("[shell_word_lexer] OK");
    end else begin
      $display("[shell_word_lexer] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_200_000;
    $display("[shell_word_lexer] ERROR");
    $finish;
  end

endmodule
